/* rtl/mrhd_pkg.sv */
// shared types, constants and helpers for the motor ramp and h-bridge drive block
package mrhd_pkg;

  localparam int DEF_CHANNELS  = 2;
  localparam int DEF_FRAC_BITS = 8;

  localparam int STEP_W  = 15;
  localparam int TGT_W   = 8;
  localparam int DUTY_W  = 7;
  localparam int PCT_MAX = 100;

  localparam logic [STEP_W-1:0] STEP_RESET = 15'd256;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  typedef struct packed {
    logic             kind;
    logic             channel;
    logic [TGT_W-1:0] target;
  } item_t;

  typedef struct packed {
    logic              brake;
    logic              reverse;
    logic [DUTY_W-1:0] duty;
  } drive_t;

  // clamp a requested percent to the legal speed range
  function automatic logic signed [TGT_W-1:0] clamp_target(input logic signed [TGT_W-1:0] t);
    logic signed [TGT_W-1:0] res;
    res = t;
    if (t > TGT_W'(PCT_MAX)) res = TGT_W'(PCT_MAX);
    if (t < -TGT_W'(PCT_MAX)) res = -TGT_W'(PCT_MAX);
    return res;
  endfunction

  // map a rounded speed (sign and magnitude) onto the bridge lines
  function automatic drive_t drive_map(input logic neg, input logic [DUTY_W-1:0] mag);
    drive_t d;
    if (mag == '0) begin
      d.brake   = 1'b1;
      d.reverse = 1'b1;
      d.duty    = DUTY_W'(PCT_MAX);
    end else if (neg) begin
      d.brake   = 1'b0;
      d.reverse = 1'b1;
      d.duty    = DUTY_W'(PCT_MAX) - mag;
    end else begin
      d.brake   = 1'b0;
      d.reverse = 1'b0;
      d.duty    = mag;
    end
    return d;
  endfunction

endpackage

/* rtl/mrhd_in_reg.sv */
// input register that holds one accepted item until the ramp stage takes it
module mrhd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  mrhd_pkg::item_t s_item,
  input  logic          consume,
  output logic          valid,
  output mrhd_pkg::item_t item
);
  import mrhd_pkg::*;

  logic accept;

  assign s_ready = !valid || consume;
  assign accept  = s_valid && s_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (consume) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= s_item;
    end
  end

endmodule

/* rtl/mrhd_ramp.sv */
// per-channel target and actual speed state with the slew step and drive mapping
module mrhd_ramp #(
  parameter int CHANNELS  = mrhd_pkg::DEF_CHANNELS,
  parameter int FRAC_BITS = mrhd_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  input  mrhd_pkg::item_t             item,
  input  logic [mrhd_pkg::STEP_W-1:0] ramp_step,
  input  logic                        buf_free,
  output logic                        consume,
  output logic                        load,
  output logic [CHANNELS-1:0]         chg_mask,
  output mrhd_pkg::drive_t            drives [CHANNELS]
);
  import mrhd_pkg::*;

  localparam int ACT_W    = FRAC_BITS + 8;
  localparam int SUM_W    = ((ACT_W > STEP_W) ? ACT_W : STEP_W) + 2;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic signed [ACT_W-1:0] act [CHANNELS];
  logic signed [TGT_W-1:0] tgt [CHANNELS];

  logic                    set_go;
  logic                    tick_go;
  logic [CH_IDX_W-1:0]     set_idx;
  logic                    set_in_range;
  logic signed [TGT_W-1:0] set_val;
  logic signed [SUM_W-1:0] step_w;

  // whole-percent magnitude, rounded half away from zero
  function automatic logic [DUTY_W-1:0] round_mag(input logic signed [ACT_W-1:0] v);
    logic [ACT_W-1:0] mag;
    logic [ACT_W-1:0] sum;
    mag = v[ACT_W-1] ? ACT_W'(-v) : ACT_W'(v);
    sum = mag + (ACT_W'(1) << (FRAC_BITS - 1));
    return DUTY_W'(sum >> FRAC_BITS);
  endfunction

  assign set_go       = valid && (item.kind == KIND_SET);
  assign tick_go      = valid && (item.kind == KIND_TICK) && buf_free;
  assign consume      = set_go || tick_go;
  assign load         = tick_go;
  assign set_idx      = CH_IDX_W'(item.channel);
  assign set_in_range = (int'(item.channel) < CHANNELS);
  assign set_val      = clamp_target(signed'(item.target));
  assign step_w       = signed'(SUM_W'(ramp_step));

  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    logic signed [SUM_W-1:0] old_w;
    logic signed [SUM_W-1:0] tgt_w;
    logic signed [SUM_W-1:0] up;
    logic signed [SUM_W-1:0] dn;
    logic signed [SUM_W-1:0] nv;
    logic signed [ACT_W-1:0] nv_act;
    logic [DUTY_W-1:0]       r_old;
    logic [DUTY_W-1:0]       r_new;

    assign old_w = SUM_W'(act[g]);
    assign tgt_w = SUM_W'(tgt[g]) <<< FRAC_BITS;
    assign up    = old_w + step_w;
    assign dn    = old_w - step_w;

    // the target never lies outside the limit, so stopping at it also bounds the value
    always_comb begin
      if (tgt_w > old_w) begin
        nv = (up > tgt_w) ? tgt_w : up;
      end else if (tgt_w < old_w) begin
        nv = (dn < tgt_w) ? tgt_w : dn;
      end else begin
        nv = old_w;
      end
    end

    assign nv_act = ACT_W'(nv);
    assign r_old  = round_mag(act[g]);
    assign r_new  = round_mag(nv_act);

    assign chg_mask[g] = (r_new != r_old) ||
                         ((r_new != '0) && (nv_act[ACT_W-1] != act[g][ACT_W-1]));
    assign drives[g]   = drive_map(nv_act[ACT_W-1], r_new);

    always_ff @(posedge clk) begin
      if (rst) begin
        act[g] <= '0;
        tgt[g] <= '0;
      end else begin
        if (tick_go) begin
          act[g] <= nv_act;
        end
        if (set_go && set_in_range && (set_idx == CH_IDX_W'(g))) begin
          tgt[g] <= set_val;
        end
      end
    end
  end

endmodule

/* rtl/mrhd_out_queue.sv */
// holds the drive results of one tick and sends them out one per transfer in channel order
module mrhd_out_queue #(
  parameter int CHANNELS = mrhd_pkg::DEF_CHANNELS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic [CHANNELS-1:0] chg_mask,
  input  mrhd_pkg::drive_t    drives [CHANNELS],
  output logic                buf_free,
  output logic                m_valid,
  input  logic                m_ready,
  output logic                m_channel,
  output mrhd_pkg::drive_t    m_drive,
  output logic                m_last
);
  import mrhd_pkg::*;

  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [CHANNELS-1:0] pending;
  drive_t              drv [CHANNELS];
  logic [CH_IDX_W-1:0] sel;
  logic                xfer;

  // lowest pending channel goes first
  always_comb begin
    sel = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (pending[i]) sel = CH_IDX_W'(i);
    end
  end

  assign m_valid   = |pending;
  assign m_last    = m_valid && ((pending & (pending - 1'b1)) == '0);
  assign m_channel = sel[0];
  assign m_drive   = drv[sel];
  assign xfer      = m_valid && m_ready;
  assign buf_free  = !m_valid || (m_last && m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (load) begin
      pending <= chg_mask;
    end else if (xfer) begin
      pending[sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < CHANNELS; i++) begin
        drv[i] <= drives[i];
      end
    end
  end

endmodule

/* rtl/motor_ramp_hbridge_drive_top.sv */
// top level of the motor speed ramp with h-bridge drive mapping
//
//  channel  | direction | signals                              | carries
//  ---------+-----------+--------------------------------------+------------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser    | set-target or tick items
//  m_*      | out       | m_tvalid m_tready m_tdata m_tlast    | drive results, tlast ends a tick
//  cfg_*    | in        | cfg_valid cfg_ready cfg_data         | ramp_step register
//
// an item waits in the input register until it is taken, then the ramp lanes update every channel
// in a single pass; a set target is taken as soon as it is in the register and gives no result
// a tick with n changed channels leaves n results, one per cycle from the output queue while
// m_tready is high, while a next tick waits in the input register
// a new tick is held only while results of the previous tick still wait on m_tready
// synchronous reset clears speeds, targets and the queue and sets ramp_step to 256
module motor_ramp_hbridge_drive_top #(
  parameter int CHANNELS  = mrhd_pkg::DEF_CHANNELS,
  parameter int FRAC_BITS = mrhd_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // channel[0], target[8:1], zero pad
  input  logic                        s_tuser,   // kind[0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // out_channel[0], brake[1], reverse[2], duty[9:3]
  output logic                        m_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mrhd_pkg::STEP_W-1:0] cfg_data
);
  import mrhd_pkg::*;

  logic [STEP_W-1:0]   ramp_step;
  item_t               s_item;
  item_t               item;
  logic                item_valid;
  logic                consume;
  logic                load;
  logic                buf_free;
  logic [CHANNELS-1:0] chg_mask;
  drive_t              drives [CHANNELS];
  logic                m_channel;
  drive_t              m_drive;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_step <= STEP_RESET;
    end else if (cfg_valid) begin
      ramp_step <= cfg_data;
    end
  end

  assign s_item.kind    = s_tuser;
  assign s_item.channel = s_tdata[0];
  assign s_item.target  = s_tdata[8:1];

  mrhd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .consume (consume),
    .valid   (item_valid),
    .item    (item)
  );

  mrhd_ramp #(
    .CHANNELS  (CHANNELS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ramp (
    .clk       (clk),
    .rst       (rst),
    .valid     (item_valid),
    .item      (item),
    .ramp_step (ramp_step),
    .buf_free  (buf_free),
    .consume   (consume),
    .load      (load),
    .chg_mask  (chg_mask),
    .drives    (drives)
  );

  mrhd_out_queue #(
    .CHANNELS (CHANNELS)
  ) u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .chg_mask  (chg_mask),
    .drives    (drives),
    .buf_free  (buf_free),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_channel (m_channel),
    .m_drive   (m_drive),
    .m_last    (m_tlast)
  );

  assign m_tdata = {6'd0, m_drive.duty, m_drive.reverse, m_drive.brake, m_channel};

endmodule

/* rtl/mrhd_checker.sv */
// port-level checks on the motor ramp drive block, bound to the top level
module mrhd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic [15:0] m_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic        m_tlast
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // input only stalls behind waiting results
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:3] <= 7'd100)
    else $error("duty above full scale");

  // brake drives both bridge lines high
  a_brake_map: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[2] && (m_tdata[9:3] == 7'd100))
    else $error("brake result with wrong line levels");

  // nonzero speed never maps onto the brake duty pattern
  a_run_map: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |->
      (m_tdata[2] && (m_tdata[9:3] != 7'd100)) || (!m_tdata[2] && (m_tdata[9:3] != 7'd0)))
    else $error("running result with impossible duty");

endmodule

bind motor_ramp_hbridge_drive_top mrhd_checker u_mrhd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast)
);

/* tb/testbench.sv */
// testbench for the two-channel motor ramp with h-bridge drive mapping
`timescale 1ns / 100ps
module testbench;
  import mrhd_pkg::*;

  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int ONE_PCT     = 1 << FRAC;
  localparam int FULL_SCALE  = PCT_MAX * ONE_PCT;
  localparam int STEP_MAX    = 25600;
  localparam int SETTLE      = 8;
  localparam int HOLD_LEN    = 400;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic              ch;
    logic              brake;
    logic              reverse;
    logic [DUTY_W-1:0] duty;
    logic              last;
  } drive_exp_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata   = '0;
  logic              s_tuser   = 1'b0;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [15:0]       m_tdata;
  logic              m_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [STEP_W-1:0] cfg_data  = '0;

  // predictor state
  int speed_fx [DEF_CHANNELS];
  int goal_pct [DEF_CHANNELS];
  int step_size = int'(STEP_RESET);

  item_t      pending_items[$];
  drive_exp_t drive_q[$];
  item_t      next_item;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_ask      = 0;
  int hold_done     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int fail_cnt      = 0;
  int ticks_seen    = 0;
  int sets_seen     = 0;
  int drives_seen   = 0;
  int step_writes   = 0;

  motor_ramp_hbridge_drive_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  function automatic string fmt_drive(input drive_exp_t d);
    return $sformatf("ch %0d brake %0d rev %0d duty %0d last %0d",
                     d.ch, d.brake, d.reverse, d.duty, d.last);
  endfunction

  // whole percent, half away from zero
  function automatic int round_pct(input int v);
    int mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + ONE_PCT / 2) >> FRAC;
    return (v < 0) ? -mag : mag;
  endfunction

  // update targets or ramp both channels, queue the drive changes a tick causes
  function automatic void advance_speeds(input logic kind, input logic [15:0] data);
    int req;
    int old;
    int tgt;
    int nv;
    int r_new;
    int n;
    drive_exp_t res;
    if (kind == KIND_SET) begin
      req = $signed(data[8:1]);
      if (req > PCT_MAX) req = PCT_MAX;
      if (req < -PCT_MAX) req = -PCT_MAX;
      goal_pct[data[0]] = req;
      sets_seen++;
      return;
    end
    ticks_seen++;
    n = 0;
    for (int i = 0; i < DEF_CHANNELS; i++) begin
      old = speed_fx[i];
      tgt = goal_pct[i] * ONE_PCT;
      if (tgt != old) begin
        if (tgt > old) begin
          nv = old + step_size;
          if (nv > FULL_SCALE) nv = FULL_SCALE;
          if (nv > tgt) nv = tgt;
        end else begin
          nv = old - step_size;
          if (nv < -FULL_SCALE) nv = -FULL_SCALE;
          if (nv < tgt) nv = tgt;
        end
        speed_fx[i] = nv;
        r_new = round_pct(nv);
        if (r_new != round_pct(old)) begin
          res.ch   = (i == 1);
          res.last = 1'b0;
          if (r_new == 0) begin
            // brake holds both bridge lines high
            res.brake   = 1'b1;
            res.reverse = 1'b1;
            res.duty    = DUTY_W'(PCT_MAX);
          end else if (r_new < 0) begin
            res.brake   = 1'b0;
            res.reverse = 1'b1;
            res.duty    = DUTY_W'(PCT_MAX + r_new);
          end else begin
            res.brake   = 1'b0;
            res.reverse = 1'b0;
            res.duty    = DUTY_W'(r_new);
          end
          drive_q.push_back(res);
          n++;
        end
      end
    end
    if (n != 0) drive_q[drive_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_drive();
    drive_exp_t want;
    drive_exp_t got;
    got.ch      = m_tdata[0];
    got.brake   = m_tdata[1];
    got.reverse = m_tdata[2];
    got.duty    = m_tdata[9:3];
    got.last    = m_tlast;
    drives_seen++;
    if (drive_q.size() == 0) begin
      note_failure({"drive transfer with nothing expected: ", fmt_drive(got)});
      return;
    end
    want = drive_q.pop_front();
    if (got.ch !== want.ch || got.brake !== want.brake || got.reverse !== want.reverse ||
        got.duty !== want.duty || got.last !== want.last)
      note_failure({"drive mismatch: expected ", fmt_drive(want), ", got ", fmt_drive(got)});
  endfunction

  function automatic void push_item(input logic kind, input logic ch, input int tgt);
    item_t it;
    it.kind    = kind;
    it.channel = ch;
    it.target  = TGT_W'(tgt);
    pending_items.push_back(it);
  endfunction

  // mostly target changes followed by runs of ticks, the rest random noise
  function automatic void fill_random(input int count);
    int made;
    int runs;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 80) begin
        for (int c = 0; c < DEF_CHANNELS; c++) begin
          if ($urandom_range(9) < 7) begin
            if ($urandom_range(9) == 0) push_item(KIND_SET, c[0], $urandom_range(255));
            else push_item(KIND_SET, c[0], int'($urandom_range(200)) - PCT_MAX);
            made++;
          end
        end
        runs = $urandom_range(1, 40);
        repeat (runs) push_item(KIND_TICK, 1'($urandom_range(1)), $urandom_range(255));
        made += runs;
      end else begin
        repeat ($urandom_range(1, 5)) begin
          push_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(255));
          made++;
        end
      end
    end
  endfunction

  function automatic int pick_step();
    case ($urandom_range(4))
      0:       return 1;
      1:       return STEP_MAX;
      2:       return 256;
      3:       return $urandom_range(1, STEP_MAX);
      default: return $urandom_range(1, 600);
    endcase
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || drive_q.size() != 0) @(negedge clk);
  endtask

  // block must be idle before the step register changes
  task automatic write_step(input int value);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= STEP_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    step_size = value;
    step_writes++;
    @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= next_item.kind;
        s_tdata  <= {7'd0, next_item.target, next_item.channel};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_ask != hold_done) begin
      hold_done <= hold_ask;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) advance_speeds(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_drive();
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d drive results outstanding",
                 quiet_cycles, drive_q.size());
        $display("[motor_ramp_hbridge_drive_top] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < DEF_CHANNELS; i++) begin
      speed_fx[i] = 0;
      goal_pct[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_idling(9, 65);

    // reset step of one percent per tick
    push_item(KIND_TICK, 1'b0, 0);        // already on target, nothing moves
    push_item(KIND_SET, 1'b0, 127);       // clamps to full forward
    push_item(KIND_SET, 1'b1, -128);      // clamps to full reverse
    push_item(KIND_TICK, 1'b1, 255);      // tick ignores channel and target
    push_item(KIND_TICK, 1'b0, 0);
    push_item(KIND_SET, 1'b0, -1);
    repeat (3) push_item(KIND_TICK, 1'b0, 0);  // left passes through brake into reverse
    push_item(KIND_SET, 1'b1, 0);
    push_item(KIND_TICK, 1'b0, 0);

    // full-scale step stops at the target and inside the range
    write_step(STEP_MAX);
    push_item(KIND_SET, 1'b0, 100);
    push_item(KIND_SET, 1'b1, -100);
    push_item(KIND_TICK, 1'b0, 0);
    push_item(KIND_SET, 1'b0, -100);
    push_item(KIND_SET, 1'b1, 100);
    repeat (2) push_item(KIND_TICK, 1'b0, 0);
    push_item(KIND_SET, 1'b0, 0);
    push_item(KIND_SET, 1'b1, 0);
    push_item(KIND_TICK, 1'b0, 0);

    // half-percent step exercises rounding away from zero
    write_step(ONE_PCT / 2);
    push_item(KIND_SET, 1'b0, 1);
    repeat (2) push_item(KIND_TICK, 1'b0, 0);
    push_item(KIND_SET, 1'b1, -1);
    push_item(KIND_TICK, 1'b0, 0);

    // zero step never moves anything
    write_step(0);
    push_item(KIND_SET, 1'b0, -100);
    repeat (2) push_item(KIND_TICK, 1'b0, 0);

    for (int mode = 0; mode < 3; mode++) begin
      for (int part = 0; part < 4; part++) begin
        if (mode == 2 && part == 0) begin
          write_step(256);
          set_idling(0, 0);
          fill_random(130);
          hold_ask++;     // receiver stalls while the sender keeps pushing
        end else begin
          write_step(pick_step());
          if (mode == 0) set_idling(9, 65);
          else if (mode == 1) set_idling(65, 9);
          else set_idling(0, 0);
          fill_random(130);
        end
      end
    end

    wait_drained();
    repeat (2 * SETTLE) @(posedge clk);
    if (drive_q.size() != 0)
      note_failure($sformatf("%0d drive results never arrived", drive_q.size()));
    $display("ran %0d ticks and %0d target updates over %0d step settings, %0d drives checked",
             ticks_seen, sets_seen, step_writes, drives_seen);
    $display("idle patterns on both sides plus a long output hold-off; %0d failures",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("[motor_ramp_hbridge_drive_top] OK");
    end else begin
      $display("[motor_ramp_hbridge_drive_top] ERROR");
    end
    $finish;
  end

endmodule
